// ===== rtl/core/bprt_pkg.sv =====
// ----------------------------------------------------------------------------
// bprt_pkg
// Shared codes and controller/datapath interface types for the radix trie engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bprt_pkg;

	localparam int NODE_DEPTH_DEF = 1024;
	localparam int KEY_WIDTH_DEF  = 64;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_EXACT  = 2'd1;
	localparam logic [1:0] REQ_PREFIX = 2'd2;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	// which node image goes to the node memory in a write cycle
	typedef enum logic [2:0] {
		WK_ROOT,
		WK_OLD,
		WK_SPLIT,
		WK_NEW,
		WK_TERM,
		WK_LEAF,
		WK_LINK
	} wk_t;

	typedef struct packed {
		logic       load;
		logic       latch;
		logic       grp_en;
		logic       msel_en;
		logic       descend;
		logic       we;
		wk_t        wk;
		logic [1:0] cnt_add;
		logic       res_load;
	} bprt_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       empty;
		logic       m_lt_plen;
		logic       m_lt_limit;
		logic       at_end;
		logic       term;
		logic       child_zero;
		logic       need2;
		logic       fit1;
		logic       fit2;
	} bprt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_radix_trie_engine_top.sv =====
// ----------------------------------------------------------------------------
// binary_radix_trie_engine_top
// Path-compressed binary trie: insert, exact lookup and prefix query on keys
// of up to KEY_WIDTH bits, nodes kept in a NODE_DEPTH-entry node memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  request  | in        | in_valid / in_ready   | req_type, key_bits, key_length
//  result   | out       | out_valid / out_ready | found, status, nodes_used
//
//  one item at a time: a load and start step, then per visited node a memory read,
//  compare, byte zero count, match select and decide, then 0 to 3 node writes,
//  then a node count update (inserts that write only) and posting of the result.
//  the node memory port and the per-node compare loop set the pace of a walk.
//  reset empties the trie at once by clearing the node count; no clearing pass.
//  a result waiting on out_ready holds only the finish of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_radix_trie_engine_top #(
	parameter int NODE_DEPTH = bprt_pkg::NODE_DEPTH_DEF,
	parameter int KEY_WIDTH  = bprt_pkg::KEY_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         req_type,
	input  logic [KEY_WIDTH-1:0]               key_bits,
	input  logic [$clog2(KEY_WIDTH+1)-1:0]     key_length,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic                               status,
	output logic [$clog2(NODE_DEPTH+1)-1:0]    nodes_used
);
	import bprt_pkg::*;

	bprt_cmd_t  cmd;
	bprt_stat_t st;

	bprt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .status(status),
		.st(st), .cmd(cmd)
	);

	bprt_dp #(.NODE_DEPTH(NODE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req_type(req_type), .key_bits(key_bits), .key_length(key_length),
		.cmd(cmd), .st(st), .nodes_used(nodes_used)
	);

endmodule

`default_nettype wire

// ===== rtl/core/bprt_ram.sv =====
// ----------------------------------------------------------------------------
// bprt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/bprt_dp.sv =====
// ----------------------------------------------------------------------------
// bprt_dp
// Trie datapath: request registers, node memories, prefix compare and node writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bprt_dp #(
	parameter int NODE_DEPTH = 1024,
	parameter int KEY_WIDTH  = 64,
	localparam int LW = $clog2(KEY_WIDTH + 1),
	localparam int CW = $clog2(NODE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             req_type,
	input  logic [KEY_WIDTH-1:0]   key_bits,
	input  logic [LW-1:0]          key_length,
	input  bprt_pkg::bprt_cmd_t    cmd,
	output bprt_pkg::bprt_stat_t   st,
	output logic [CW-1:0]          nodes_used
);
	import bprt_pkg::*;

	localparam int AW    = $clog2(NODE_DEPTH);
	localparam int LINKW = LW + 1 + 2 * AW;
	localparam int G     = (KEY_WIDTH + 7) / 8;
	localparam int GW    = G * 8;
	localparam logic [LW-1:0] KW = LW'(KEY_WIDTH);

	function automatic logic [KEY_WIDTH-1:0] low_mask(input logic [LW-1:0] n);
		logic [KEY_WIDTH-1:0] ones;
		ones = '1;
		return (n >= KW) ? ones : ~(ones << n);
	endfunction

	logic [KEY_WIDTH-1:0] key_q, pre_q, diff_s1;
	logic [LW-1:0]        len_q, cons_q, plen_q, lim_s1, m_q;
	logic [1:0]           type_q;
	logic [AW-1:0]        cur_q, c0_q, c1_q;
	logic                 term_q;
	logic [CW-1:0]        count_q, used_q;
	logic                 gany_s2 [G];
	logic [2:0]           glz_s2  [G];

	logic [KEY_WIDTH-1:0] rd_pre, wpre;
	logic [LINKW-1:0]     rd_link, wlink;
	logic [AW-1:0]        wa, ram_addr;

	// memories
	bprt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(NODE_DEPTH)) u_pre_ram (
		.clk(clk), .we(cmd.we), .addr(ram_addr), .wdata(wpre), .rdata(rd_pre)
	);
	bprt_ram #(.WIDTH(LINKW), .DEPTH(NODE_DEPTH)) u_link_ram (
		.clk(clk), .we(cmd.we), .addr(ram_addr), .wdata(wlink), .rdata(rd_link)
	);

	assign ram_addr = cmd.we ? wa : cur_q;

	logic [LW-1:0] rd_plen;
	logic          rd_term;
	logic [AW-1:0] rd_c0, rd_c1;
	assign rd_plen = rd_link[LINKW-1 -: LW];
	assign rd_term = rd_link[2*AW];
	assign rd_c0   = rd_link[2*AW-1 -: AW];
	assign rd_c1   = rd_link[AW-1:0];

	// load-side length saturation
	logic [LW-1:0] len_c;
	assign len_c = (key_length > KW) ? KW : key_length;

	// compare stage: align node prefix and remaining key at the msb
	logic [LW-1:0]        rem, lim_rd, lim;
	logic [KEY_WIDTH-1:0] pa, kal, tmask, diff_n, ones_w;
	assign ones_w = '1;
	assign rem    = len_q - cons_q;
	assign lim_rd = (rd_plen < rem) ? rd_plen : rem;
	assign lim    = (plen_q < rem) ? plen_q : rem;
	assign pa     = rd_pre << (KW - rd_plen);
	assign kal    = key_q << (KW - rem);
	assign tmask  = ~(ones_w >> lim_rd);
	assign diff_n = (pa ^ kal) & tmask;

	// group stage: per-byte leading zero count
	logic [GW-1:0] dpad;
	logic          gany_n [G];
	logic [2:0]    glz_n  [G];
	assign dpad = GW'(diff_s1) << (GW - KEY_WIDTH);

	always_comb begin
		logic [7:0] grp;
		logic       f;
		for (int g = 0; g < G; g++) begin
			grp = dpad[GW-1-8*g -: 8];
			f = 1'b0;
			glz_n[g] = 3'd0;
			for (int i = 0; i < 8; i++) begin
				if (!f && grp[7-i]) begin
					f = 1'b1;
					glz_n[g] = 3'(i);
				end
			end
			gany_n[g] = |grp;
		end
	end

	// select stage: first differing group gives the match length
	logic [LW-1:0] m_n;
	always_comb begin
		logic hit;
		hit = 1'b0;
		m_n = lim_s1;
		for (int g = 0; g < G; g++) begin
			if (!hit && gany_s2[g]) begin
				hit = 1'b1;
				m_n = LW'(g * 8) + LW'(glz_s2[g]);
			end
		end
	end

	// decision terms
	logic [LW-1:0]        cons_n, newrem, oldrem, oldrem_m1, newrem_m1, rem_leaf, bidx;
	logic [KEY_WIDTH-1:0] key_sh, pre_sh;
	logic                 b, obranch, cvalid;
	logic [AW-1:0]        c_raw, cidx, cnt_idx, new_idx, sc0, sc1, cn;
	logic [CW:0]          cnt_x;

	assign cons_n    = cons_q + m_q;
	assign newrem    = rem - m_q;
	assign oldrem    = plen_q - m_q;
	assign oldrem_m1 = oldrem - LW'(1);
	assign newrem_m1 = newrem - LW'(1);
	assign rem_leaf  = len_q - cons_n - LW'(1);
	assign bidx      = len_q - LW'(1) - cons_n;
	assign key_sh    = key_q >> bidx;
	assign b         = key_sh[0];
	assign pre_sh    = pre_q >> oldrem_m1;
	assign obranch   = pre_sh[0];
	assign c_raw     = b ? c1_q : c0_q;
	assign cvalid    = CW'(c_raw) < count_q;
	assign cidx      = cvalid ? c_raw : '0;
	assign cnt_idx   = count_q[AW-1:0];
	assign new_idx   = cnt_idx + AW'(1);
	assign cnt_x     = {1'b0, count_q};
	assign cn        = (newrem != '0) ? new_idx : '0;
	assign sc0       = obranch ? cn : cnt_idx;
	assign sc1       = obranch ? cnt_idx : cn;

	always_comb begin
		st.req        = type_q;
		st.empty      = (count_q == '0);
		st.m_lt_plen  = m_q < plen_q;
		st.m_lt_limit = m_q < lim;
		st.at_end     = cons_n >= len_q;
		st.term       = term_q;
		st.child_zero = (cidx == '0);
		st.need2      = (newrem != '0);
		st.fit1       = (cnt_x + (CW+1)'(1)) <= (CW+1)'(NODE_DEPTH);
		st.fit2       = (cnt_x + (CW+1)'(2)) <= (CW+1)'(NODE_DEPTH);
	end

	// write image select
	always_comb begin
		wa    = cur_q;
		wpre  = pre_q;
		wlink = {plen_q, term_q, c0_q, c1_q};
		case (cmd.wk)
			WK_ROOT: begin
				wa    = '0;
				wpre  = key_q;
				wlink = {len_q, 1'b1, {AW{1'b0}}, {AW{1'b0}}};
			end
			WK_OLD: begin
				wa    = cnt_idx;
				wpre  = pre_q & low_mask(oldrem_m1);
				wlink = {oldrem_m1, term_q, c0_q, c1_q};
			end
			WK_SPLIT: begin
				wpre  = (m_q == '0) ? '0 : (pre_q >> oldrem);
				wlink = {m_q, (newrem == '0), sc0, sc1};
			end
			WK_NEW: begin
				wa    = new_idx;
				wpre  = key_q & low_mask(newrem_m1);
				wlink = {newrem_m1, 1'b1, {AW{1'b0}}, {AW{1'b0}}};
			end
			WK_TERM: begin
				wlink = {plen_q, 1'b1, c0_q, c1_q};
			end
			WK_LEAF: begin
				wa    = cnt_idx;
				wpre  = key_q & low_mask(rem_leaf);
				wlink = {rem_leaf, 1'b1, {AW{1'b0}}, {AW{1'b0}}};
			end
			WK_LINK: begin
				wlink = b ? {plen_q, term_q, c0_q, cnt_idx} : {plen_q, term_q, cnt_idx, c1_q};
			end
			default: begin
				wa = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_add != 2'd0) begin
			count_q <= count_q + CW'(cmd.cnt_add);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			len_q  <= len_c;
			key_q  <= key_bits & low_mask(len_c);
			cons_q <= '0;
			cur_q  <= '0;
		end
		if (cmd.descend) begin
			cur_q  <= cidx;
			cons_q <= cons_n + LW'(1);
		end
		if (cmd.latch) begin
			pre_q   <= rd_pre;
			plen_q  <= rd_plen;
			term_q  <= rd_term;
			c0_q    <= rd_c0;
			c1_q    <= rd_c1;
			diff_s1 <= diff_n;
			lim_s1  <= lim_rd;
		end
		if (cmd.grp_en) begin
			gany_s2 <= gany_n;
			glz_s2  <= glz_n;
		end
		if (cmd.msel_en) begin
			m_q <= m_n;
		end
		if (cmd.res_load) begin
			used_q <= count_q;
		end
	end

	assign nodes_used = used_q;

endmodule

`default_nettype wire

// ===== rtl/core/bprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bprt_ctrl
// Walk sequencer: steps the datapath through node reads, compares and writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bprt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic                 status,
	input  bprt_pkg::bprt_stat_t st,
	output bprt_pkg::bprt_cmd_t  cmd
);
	import bprt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_RD, S_LAT, S_GRP, S_MSEL, S_EVAL,
		S_W_ROOT, S_W_OLD, S_W_SPLIT, S_W_NEW, S_W_TERM, S_W_LEAF, S_W_LINK,
		S_CNT, S_FIN
	} state_t;

	state_t     state_q, ev_next;
	logic       out_valid_q, found_q, status_q, fd_q, fl_q;
	logic [1:0] add_q, ev_add;
	logic       ev_found, ev_full, ev_desc, fin_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign status    = status_q;
	assign fin_go    = !out_valid_q || out_ready;

	// decision after a node compare
	always_comb begin
		ev_next  = S_FIN;
		ev_add   = 2'd0;
		ev_found = 1'b0;
		ev_full  = 1'b0;
		ev_desc  = 1'b0;
		case (st.req)
			REQ_INSERT: begin
				if (st.m_lt_plen) begin
					if (st.need2 ? st.fit2 : st.fit1) begin
						ev_next = S_W_OLD;
						ev_add  = st.need2 ? 2'd2 : 2'd1;
					end else begin
						ev_full = 1'b1;
					end
				end else if (st.at_end) begin
					ev_next = S_W_TERM;
				end else if (st.child_zero) begin
					if (st.fit1) begin
						ev_next = S_W_LEAF;
						ev_add  = 2'd1;
					end else begin
						ev_full = 1'b1;
					end
				end else begin
					ev_desc = 1'b1;
					ev_next = S_RD;
				end
			end
			REQ_EXACT, REQ_PREFIX: begin
				if ((st.req == REQ_EXACT) ? st.m_lt_plen : st.m_lt_limit) begin
					ev_found = 1'b0;
				end else if (st.at_end) begin
					ev_found = (st.req == REQ_EXACT) ? st.term : 1'b1;
				end else if (!st.child_zero) begin
					ev_desc = 1'b1;
					ev_next = S_RD;
				end
			end
			default: begin
				ev_next = S_FIN;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.wk = WK_ROOT;
		case (state_q)
			S_IDLE:    cmd.load = in_valid;
			S_LAT:     cmd.latch = 1'b1;
			S_GRP:     cmd.grp_en = 1'b1;
			S_MSEL:    cmd.msel_en = 1'b1;
			S_EVAL:    cmd.descend = ev_desc;
			S_W_ROOT:  begin cmd.we = 1'b1; cmd.wk = WK_ROOT;  end
			S_W_OLD:   begin cmd.we = 1'b1; cmd.wk = WK_OLD;   end
			S_W_SPLIT: begin cmd.we = 1'b1; cmd.wk = WK_SPLIT; end
			S_W_NEW:   begin cmd.we = 1'b1; cmd.wk = WK_NEW;   end
			S_W_TERM:  begin cmd.we = 1'b1; cmd.wk = WK_TERM;  end
			S_W_LEAF:  begin cmd.we = 1'b1; cmd.wk = WK_LEAF;  end
			S_W_LINK:  begin cmd.we = 1'b1; cmd.wk = WK_LINK;  end
			S_CNT:     cmd.cnt_add = add_q;
			S_FIN:     cmd.res_load = fin_go;
			default:   cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			status_q    <= ST_DONE;
			fd_q        <= 1'b0;
			fl_q        <= ST_DONE;
			add_q       <= 2'd0;
		end else begin
			if (state_q == S_FIN && fin_go) begin
				out_valid_q <= 1'b1;
				found_q     <= fd_q;
				status_q    <= fl_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						fd_q    <= 1'b0;
						fl_q    <= ST_DONE;
						add_q   <= 2'd0;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (st.req != REQ_INSERT && st.req != REQ_EXACT && st.req != REQ_PREFIX) begin
						state_q <= S_FIN;
					end else if (st.empty) begin
						if (st.req == REQ_INSERT) begin
							add_q   <= 2'd1;
							state_q <= S_W_ROOT;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD:      state_q <= S_LAT;
				S_LAT:     state_q <= S_GRP;
				S_GRP:     state_q <= S_MSEL;
				S_MSEL:    state_q <= S_EVAL;
				S_EVAL: begin
					fd_q    <= ev_found;
					fl_q    <= ev_full ? ST_FULL : ST_DONE;
					add_q   <= ev_add;
					state_q <= ev_next;
				end
				S_W_ROOT:  state_q <= S_CNT;
				S_W_OLD:   state_q <= S_W_SPLIT;
				S_W_SPLIT: state_q <= st.need2 ? S_W_NEW : S_CNT;
				S_W_NEW:   state_q <= S_CNT;
				S_W_TERM:  state_q <= S_CNT;
				S_W_LEAF:  state_q <= S_W_LINK;
				S_W_LINK:  state_q <= S_CNT;
				S_CNT:     state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bprt_chk.sv =====
// ----------------------------------------------------------------------------
// bprt_chk
// Port-level checks for the radix trie engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bprt_chk #(
	parameter int NODE_DEPTH = 1024,
	parameter int KEY_WIDTH  = 64
) (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_ready,
	input wire [1:0]                      req_type,
	input wire [KEY_WIDTH-1:0]            key_bits,
	input wire [$clog2(KEY_WIDTH+1)-1:0]  key_length,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire                            found,
	input wire                            status,
	input wire [$clog2(NODE_DEPTH+1)-1:0] nodes_used
);
	import bprt_pkg::*;

	// waiting request item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(req_type) && $stable(key_bits)
			&& $stable(key_length))
		else $error("request item changed while waiting");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(status)
			&& $stable(nodes_used))
		else $error("result changed while stalled");

	// a refused insert never answers found
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> !found)
		else $error("full status with found set");

	// refusal only when at most one node is free
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> 32'(nodes_used) + 1 >= NODE_DEPTH)
		else $error("insert refused with free nodes left");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(nodes_used) <= NODE_DEPTH)
		else $error("node count beyond memory depth");

endmodule

bind binary_radix_trie_engine_top bprt_chk #(
	.NODE_DEPTH(NODE_DEPTH), .KEY_WIDTH(KEY_WIDTH)
) u_bprt_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.req_type(req_type), .key_bits(key_bits), .key_length(key_length),
	.out_valid(out_valid), .out_ready(out_ready), .found(found),
	.status(status), .nodes_used(nodes_used)
);

`default_nettype wire
